>>> hdl/clist_pkg.sv
`default_nettype none
package clist_pkg;

  // Field widths of the request and result channels
  localparam int OP_W  = 4;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int LEN_W = 7;
  localparam int IDX_W = 6;
  localparam int ST_W  = 2;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;
  typedef logic [1:0]      cell_act_t;

  // Command codes
  localparam op_t OP_INSERT = 4'd0;
  localparam op_t OP_APPEND = 4'd1;
  localparam op_t OP_REMOVE = 4'd2;
  localparam op_t OP_START  = 4'd3;
  localparam op_t OP_END    = 4'd4;
  localparam op_t OP_PREV   = 4'd5;
  localparam op_t OP_NEXT   = 4'd6;
  localparam op_t OP_SEEK   = 4'd7;
  localparam op_t OP_READ   = 4'd8;
  localparam op_t OP_FIND   = 4'd9;
  localparam op_t OP_CLEAR  = 4'd10;

  // Result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // Broadcast action to the cell row
  localparam cell_act_t CELL_HOLD = 2'd0;
  localparam cell_act_t CELL_PUT  = 2'd1;  // open a slot at the index and write it
  localparam cell_act_t CELL_TAKE = 2'd2;  // close the slot at the index

  typedef struct packed {
    op_t              operation;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] item_value;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic [LEN_W-1:0] length;
    logic [IDX_W-1:0] cursor_index;
    status_t          status;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/clist_if.sv
`default_nettype none
// Request channel
interface clist_in_if import clist_pkg::*; ();
  logic             valid;
  logic             ready;
  op_t              operation;
  logic [VAL_W-1:0] value;
  logic [POS_W-1:0] position;

  modport source (output valid, output operation, output value, output position, input ready);
  modport sink   (input valid, input operation, input value, input position, output ready);
endinterface

// Result channel
interface clist_out_if import clist_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] item_value;
  logic             found;
  logic [IDX_W-1:0] found_index;
  logic [LEN_W-1:0] length;
  logic [IDX_W-1:0] cursor_index;
  status_t          status;

  modport source (output valid, output item_value, output found, output found_index,
                  output length, output cursor_index, output status, input ready);
  modport sink   (input valid, input item_value, input found, input found_index,
                  input length, input cursor_index, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/cursor_list_engine_top.sv
`default_nettype none
// Bounded ordered list with a cursor, one command per request.
// in_chan (valid/ready): operation, value, position. A request is taken at a
//   clock edge with valid and ready high; ready is high while the engine is
//   idle, i.e. between commands.
// out_chan (valid/ready): one result per request with item_value, found,
//   found_index, length, cursor_index and status.
// The list lives in a row of CAPACITY cells; insert and remove shift the
// cells behind the index by one place at once, each cell taking
// its neighbor's element.
// The result is registered when the command executes; for find, the cell
// compares are registered first and the first match is encoded from them.
// A new request is taken only once the current command has completed.
// A waiting result does not block the next request; that request completes
// only once the output register is free again.
// Reset (rst_n low, synchronous) empties the list, puts the cursor at 0 and
// drops any pending result; element storage is not cleared.
module cursor_list_engine_top import clist_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  clist_in_if.sink   in_chan,
  clist_out_if.source out_chan
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [1:0]          state_r;
  cmd_t                cmd_r;
  res_t                res_r;
  logic                out_valid_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   match_vec;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] item;

  cell_act_t     act, cell_act;
  logic [IW-1:0] at, rd_idx, last;
  logic          item_sel, full, empty, at_end, slot_free, commit, res_load;
  status_t       status;
  logic          enc_found;
  logic [IW-1:0] enc_idx;

  assign key       = DATA_WIDTH'(cmd_r.value[VW-1:0]);
  assign full      = (cnt_r == CW'(CAPACITY));
  assign empty     = (cnt_r == '0);
  assign last      = IW'(cnt_r - CW'(1));
  assign at_end    = (cur_r >= last);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign commit    = (state_r == S_EXEC) && (cmd_r.operation != OP_FIND) && slot_free;
  assign res_load  = commit || ((state_r == S_FIND) && slot_free);
  assign cell_act  = commit ? act : CELL_HOLD;

  // Command decode: next length, cursor, cell action and status
  always_comb begin
    act      = CELL_HOLD;
    at       = '0;
    cnt_nxt  = cnt_r;
    cur_nxt  = cur_r;
    status   = ST_OK;
    rd_idx   = cur_r;
    item_sel = 1'b0;
    case (cmd_r.operation)
      OP_INSERT, OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          act     = CELL_PUT;
          if (empty) begin
            at = '0;
          end else if (cmd_r.operation == OP_INSERT) begin
            at = cur_r;
          end else begin
            at = IW'(cnt_r);
          end
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          act      = CELL_TAKE;
          at       = at_end ? last : cur_r;
          rd_idx   = at_end ? last : cur_r;
          item_sel = 1'b1;
          cnt_nxt  = cnt_r - CW'(1);
          if (at_end) begin
            cur_nxt = (cnt_r == CW'(1)) ? '0 : IW'(cnt_r - CW'(2));
          end
        end
      end
      OP_START: begin
        if (empty) status = ST_EMPTY;
        else cur_nxt = '0;
      end
      OP_END: begin
        if (empty) status = ST_EMPTY;
        else cur_nxt = last;
      end
      OP_PREV: begin
        if (empty) status = ST_EMPTY;
        else if (cur_r != '0) cur_nxt = cur_r - IW'(1);
      end
      OP_NEXT: begin
        if (empty) status = ST_EMPTY;
        else if (!at_end) cur_nxt = cur_r + IW'(1);
      end
      OP_SEEK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (XW'(cmd_r.position) >= XW'(cnt_r)) begin
          status = ST_RANGE;
        end else begin
          cur_nxt = IW'(cmd_r.position);
        end
      end
      OP_READ: begin
        if (empty) status = ST_EMPTY;
        else item_sel = 1'b1;
      end
      OP_FIND: begin
        if (empty) status = ST_EMPTY;
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
        cur_nxt = '0;
      end
      default: ;
    endcase
  end

  assign item = item_sel ? cell_data[rd_idx] : '0;

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d;
    if (g == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    clist_cell #(
      .DW (DATA_WIDTH),
      .IW (IW),
      .CW (CW),
      .IDX(g)
    ) u_cell (
      .clk       (clk),
      .act       (cell_act),
      .at        (at),
      .cnt       (cnt_r),
      .new_data  (key),
      .key       (key),
      .left_data (left_d),
      .right_data(right_d),
      .data      (cell_data[g]),
      .match     (match_vec[g])
    );
  end

  clist_find #(
    .N (CAPACITY),
    .IW(IW)
  ) u_find (
    .match(match_vec),
    .found(enc_found),
    .index(enc_idx)
  );

  // Sequencer and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      cur_r       <= '0;
    end else begin
      // result valid: set on a finished command, cleared when taken
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_r.operation == OP_FIND) begin
            state_r <= S_FIND;
          end else if (slot_free) begin
            cnt_r       <= cnt_nxt;
            cur_r       <= cur_nxt;
            state_r     <= S_IDLE;
          end
        end
        S_FIND: begin
          if (slot_free) begin
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Request and result payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_chan.valid) begin
      cmd_r.operation <= in_chan.operation;
      cmd_r.value     <= in_chan.value;
      cmd_r.position  <= in_chan.position;
    end
    if (res_load) begin
      res_r.item_value   <= VAL_W'(item[VW-1:0]);
      res_r.found        <= (state_r == S_FIND) && enc_found;
      res_r.found_index  <= (state_r == S_FIND && enc_found) ? IDX_W'(enc_idx) : '0;
      res_r.length       <= LEN_W'(cnt_nxt);
      res_r.cursor_index <= IDX_W'(cur_nxt);
      res_r.status       <= status;
    end
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.item_value   = res_r.item_value;
  assign out_chan.found        = res_r.found;
  assign out_chan.found_index  = res_r.found_index;
  assign out_chan.length       = res_r.length;
  assign out_chan.cursor_index = res_r.cursor_index;
  assign out_chan.status       = res_r.status;

endmodule
`default_nettype wire

>>> hdl/clist_cell.sv
`default_nettype none
// One list slot: holds an element, shifts with its neighbors, compares to the key.
module clist_cell import clist_pkg::*; #(
  parameter int DW  = 32,
  parameter int IW  = 6,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire cell_act_t     act,
  input  wire logic [IW-1:0] at,
  input  wire logic [CW-1:0] cnt,
  input  wire logic [DW-1:0] new_data,
  input  wire logic [DW-1:0] key,
  input  wire logic [DW-1:0] left_data,
  input  wire logic [DW-1:0] right_data,
  output logic      [DW-1:0] data,
  output logic               match
);

  localparam logic [CW-1:0] MY = CW'(IDX);

  logic [DW-1:0] data_r, data_nxt;
  logic          match_r;
  logic [CW-1:0] at_x;

  assign at_x = CW'(at);

  // Shift / write decision for this slot
  always_comb begin
    data_nxt = data_r;
    case (act)
      CELL_PUT: begin
        if (MY == at_x) begin
          data_nxt = new_data;
        end else if (MY > at_x && MY <= cnt) begin
          data_nxt = left_data;
        end
      end
      CELL_TAKE: begin
        if (MY >= at_x && (MY + CW'(1)) < cnt) begin
          data_nxt = right_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= (data_r == key) && (MY < cnt);
  end

  assign data  = data_r;
  assign match = match_r;

endmodule
`default_nettype wire

>>> hdl/clist_find.sv
`default_nettype none
// First-match encoder over the registered match flags of the cell row.
module clist_find #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  wire logic [N-1:0]  match,
  output logic               found,
  output logic      [IW-1:0] index
);

  // lowest set flag wins
  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        index = IW'(i);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/clist_check.sv
`default_nettype none
// Port-level checks on the result channel.
module clist_check import clist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [VAL_W-1:0] out_item_value,
  input wire logic             out_found,
  input wire logic [LEN_W-1:0] out_length,
  input wire logic [IDX_W-1:0] out_cursor_index,
  input wire status_t          out_status
);

  localparam bit SMALL = (CAPACITY <= 64);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_value) &&
                                $stable(out_length) && $stable(out_cursor_index))
    else $error("result changed while stalled");

  // cursor stays inside a nonempty list
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL && out_length != '0 |-> LEN_W'(out_cursor_index) < out_length)
    else $error("cursor beyond list end");

  // empty list parks the cursor at the head
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length == '0 |-> out_cursor_index == '0)
    else $error("cursor not at head of empty list");

  // full flag only on a full list
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL && out_status == ST_FULL |-> out_length == LEN_W'(CAPACITY))
    else $error("full status with room left");

  // a flagged command never reports a match or an element
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_found && out_item_value == '0)
    else $error("flagged command returned data");

endmodule

bind cursor_list_engine_top clist_check #(.CAPACITY(CAPACITY)) u_clist_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_item_value  (out_chan.item_value),
  .out_found       (out_chan.found),
  .out_length      (out_chan.length),
  .out_cursor_index(out_chan.cursor_index),
  .out_status      (out_chan.status)
);
`default_nettype wire

>>> tb/list_mirror_check.sv
// Watches both channels, keeps a mirror of the list and compares every result
module list_mirror_check import clist_pkg::*; #(
  parameter int CAP = 64
) (
  input  logic clk,
  input  logic rst_n,
  clist_in_if  req,
  clist_out_if rsp,
  output int   mismatches,
  output int   outstanding
);

  logic [VAL_W-1:0] mirror_elems [CAP];
  int   mirror_len = 0;
  int   mirror_cur = 0;
  res_t expected_q [$];
  int   miss_cnt = 0;
  int   left_cnt = 0;

  assign mismatches  = miss_cnt;
  assign outstanding = left_cnt;

  // Apply one command to the mirror and return the result it should produce
  function automatic res_t apply_list_cmd(op_t op, logic [VAL_W-1:0] key,
                                          logic [POS_W-1:0] pos);
    res_t r;
    int   k;
    bit   hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    if (op == OP_INSERT || op == OP_APPEND) begin
      if (mirror_len >= CAP) begin
        r.status = ST_FULL;
      end else if (mirror_len == 0) begin
        mirror_elems[0] = key;
        mirror_len = 1;
        mirror_cur = 0;
      end else if (op == OP_INSERT) begin
        // open a slot at the cursor; the cursor now marks the new element
        for (k = mirror_len; k > mirror_cur; k--)
          mirror_elems[k] = mirror_elems[k-1];
        mirror_elems[mirror_cur] = key;
        mirror_len++;
      end else begin
        mirror_elems[mirror_len] = key;
        mirror_len++;
      end
    end else if (op == OP_CLEAR) begin
      mirror_len = 0;
      mirror_cur = 0;
    end else if (op > OP_CLEAR) begin
      // undefined codes: no effect
    end else if (mirror_len == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (op)
        OP_REMOVE: begin
          if (mirror_cur >= mirror_len - 1) begin
            // tail remove: cursor steps back
            r.item_value = mirror_elems[mirror_len-1];
            mirror_len--;
            mirror_cur = (mirror_len == 0) ? 0 : mirror_len - 1;
          end else begin
            r.item_value = mirror_elems[mirror_cur];
            for (k = mirror_cur; k + 1 < mirror_len; k++)
              mirror_elems[k] = mirror_elems[k+1];
            mirror_len--;
          end
        end
        OP_START: mirror_cur = 0;
        OP_END:   mirror_cur = mirror_len - 1;
        OP_PREV:  if (mirror_cur > 0) mirror_cur--;
        OP_NEXT:  if (mirror_cur + 1 < mirror_len) mirror_cur++;
        OP_SEEK: begin
          if (int'(pos) >= mirror_len) r.status = ST_RANGE;
          else mirror_cur = int'(pos);
        end
        OP_READ:  r.item_value = mirror_elems[mirror_cur];
        default: begin
          // find: first match from the head
          for (k = 0; k < mirror_len; k++) begin
            if (!hit && mirror_elems[k] == key) begin
              hit = 1'b1;
              r.found = 1'b1;
              r.found_index = k[IDX_W-1:0];
            end
          end
        end
      endcase
    end
    r.length       = mirror_len[LEN_W-1:0];
    r.cursor_index = mirror_cur[IDX_W-1:0];
    return r;
  endfunction

  // Results are checked before new requests are mirrored
  always @(posedge clk) begin
    res_t want;
    res_t got;
    bit   bad;
    if (rst_n) begin
      if (rsp.valid && rsp.ready) begin
        got.item_value   = rsp.item_value;
        got.found        = rsp.found;
        got.found_index  = rsp.found_index;
        got.length       = rsp.length;
        got.cursor_index = rsp.cursor_index;
        got.status       = rsp.status;
        if (expected_q.size() == 0) begin
          if (miss_cnt < 10)
            $display("unexpected result: item=%h len=%0d cur=%0d st=%0d",
                     got.item_value, got.length, got.cursor_index, got.status);
          miss_cnt <= miss_cnt + 1;
        end else begin
          want = expected_q.pop_front();
          bad = (got.item_value !== want.item_value) || (got.found !== want.found) ||
                (got.found_index !== want.found_index) || (got.length !== want.length) ||
                (got.cursor_index !== want.cursor_index) || (got.status !== want.status);
          if (bad) begin
            if (miss_cnt < 10) begin
              $display("mismatch exp: item=%h found=%0d fidx=%0d len=%0d cur=%0d st=%0d",
                       want.item_value, want.found, want.found_index, want.length,
                       want.cursor_index, want.status);
              $display("         got: item=%h found=%0d fidx=%0d len=%0d cur=%0d st=%0d",
                       got.item_value, got.found, got.found_index, got.length,
                       got.cursor_index, got.status);
            end
            miss_cnt <= miss_cnt + 1;
          end
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(apply_list_cmd(req.operation, req.value, req.position));
      left_cnt <= expected_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// Drives list commands, stalls the result side, gives the verdict
module tb;
  import clist_pkg::*;

  localparam int  CYCLE_LIMIT = 300000;
  localparam int  RAND_CMDS   = 1750;
  localparam op_t OP_TOP_CODE = 4'hF;

  // Traffic mix for a block of random requests
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;
  int   cycle_cnt = 0;
  int   mismatches;
  int   outstanding;
  logic [VAL_W-1:0] key_pool [8];

  clist_in_if  cmd_bus ();
  clist_out_if res_bus ();

  cursor_list_engine_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_bus),
    .out_chan (res_bus)
  );

  list_mirror_check i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (cmd_bus),
    .rsp         (res_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_bus.ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // One request: random idle cycles, then hold valid until taken
  task automatic issue_cmd(input op_t op, input logic [VAL_W-1:0] v,
                           input logic [POS_W-1:0] p);
    while (!calm && $urandom_range(99) < 22) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.operation <= op;
    cmd_bus.value     <= v;
    cmd_bus.position  <= p;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
  endtask

  // Hold off until every result is back
  task automatic drain;
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic op_t pick_op(int mix);
    int r;
    int s;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW: begin
        if (r < 35) return OP_INSERT;
        if (r < 60) return OP_APPEND;
        if (r < 68) return OP_REMOVE;
      end
      MIX_SHRINK: begin
        if (r < 10) return OP_INSERT;
        if (r < 15) return OP_APPEND;
        if (r < 50) return OP_REMOVE;
      end
      default: begin
        if (r < 20) return OP_INSERT;
        if (r < 35) return OP_APPEND;
        if (r < 55) return OP_REMOVE;
      end
    endcase
    s = $urandom_range(99);
    if (s < 12) return OP_START;
    if (s < 24) return OP_END;
    if (s < 36) return OP_PREV;
    if (s < 48) return OP_NEXT;
    if (s < 64) return OP_SEEK;
    if (s < 78) return OP_READ;
    if (s < 94) return OP_FIND;
    if (s < 97) return (mix == MIX_GROW) ? OP_READ : OP_CLEAR;
    return op_t'($urandom_range(OP_TOP_CODE, OP_CLEAR + 1));
  endfunction

  // Values repeat often enough for find to hit
  function automatic logic [VAL_W-1:0] pick_value;
    int r;
    r = $urandom_range(99);
    if (r < 40) return key_pool[$urandom_range(7)];
    if (r < 45) return '0;
    if (r < 50) return '1;
    return $urandom;
  endfunction

  initial begin
    int mix;
    rst_n             <= 1'b0;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.operation <= OP_READ;
    cmd_bus.value     <= '0;
    cmd_bus.position  <= '0;
    for (int k = 0; k < 8; k++) key_pool[k] = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every defined command but insert, append and clear is flagged
    issue_cmd(OP_REMOVE, '0, '0);
    issue_cmd(OP_READ,   '0, '0);
    issue_cmd(OP_FIND,   '0, '0);
    issue_cmd(OP_SEEK,   '0, '0);
    issue_cmd(OP_START,  '0, '0);
    issue_cmd(OP_END,    '0, '0);
    issue_cmd(OP_PREV,   '0, '0);
    issue_cmd(OP_NEXT,   '0, '0);
    // Build a short list, insert in the middle
    issue_cmd(OP_INSERT, '0, '0);
    issue_cmd(OP_APPEND, '1, '1);
    issue_cmd(OP_APPEND, 32'h5A5A_A5A5, '0);
    issue_cmd(OP_SEEK,   '0, 6'd1);
    issue_cmd(OP_INSERT, 32'h1234_5678, '0);
    issue_cmd(OP_READ,   '0, '0);
    issue_cmd(OP_FIND,   '1, '0);
    issue_cmd(OP_FIND,   32'hDEAD_BEEF, '0);
    issue_cmd(OP_SEEK,   '0, '1);
    // Cursor stays at either end
    issue_cmd(OP_START,  '0, '0);
    issue_cmd(OP_PREV,   '0, '0);
    issue_cmd(OP_END,    '0, '0);
    issue_cmd(OP_NEXT,   '0, '0);
    // Tail remove, head remove, last element remove
    issue_cmd(OP_REMOVE, '0, '0);
    issue_cmd(OP_START,  '0, '0);
    issue_cmd(OP_REMOVE, '0, '0);
    issue_cmd(OP_CLEAR,  '0, '0);
    issue_cmd(OP_INSERT, 32'hA5A5_5A5A, '0);
    issue_cmd(OP_REMOVE, '0, '0);
    issue_cmd(OP_TOP_CODE, '1, '1);
    drain();

    mix = MIX_EVEN;
    for (int i = 0; i < RAND_CMDS; i++) begin
      if (i % 125 == 0) mix = $urandom_range(MIX_EVEN, MIX_GROW);
      calm = (i >= 700 && i < 1000);
      if (i == 400 || i == 1200) drain();
      issue_cmd(pick_op(mix), pick_value(),
                ($urandom_range(99) < 60) ? POS_W'($urandom_range(15))
                                          : POS_W'($urandom_range(63)));
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
